[hdl/cube_face_tessellator_top_assert.svh]
// Assertion macros for the cube face tessellator.
`ifndef CUBE_FACE_TESSELLATOR_TOP_ASSERT_SVH
`define CUBE_FACE_TESSELLATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cube_face_tessellator assertion failed");

// Implication whose consequent may use ## delays.
`define CFT_ASSERT_SEQ(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("cube_face_tessellator assertion failed");

`endif

[hdl/cft_pkg.sv]
package cft_pkg;

  localparam int unsigned MaxDivisions = 64;
  localparam int unsigned FracBits     = 15;

  localparam int unsigned DivW   = 7;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned FaceW  = 3;
  localparam int unsigned PosW   = 16;
  localparam int unsigned NormW  = 2;
  localparam int unsigned VtxW   = 3;

  // floor(x / (2n)) as (x * ceil(2^RcpShift / (2n))) >> RcpShift, exact for x < 2^23
  localparam int unsigned RcpShift = 30;
  localparam int unsigned RcpW     = RcpShift;
  localparam int unsigned NumW     = DivW + FracBits + 1;
  localparam int unsigned ProdW    = NumW + RcpW;
  localparam int unsigned RcpOne   = (1 << RcpShift) / 2;

  localparam int unsigned Half     = 1 << (FracBits - 1);
  localparam int unsigned One      = 1 << FracBits;
  localparam logic [VtxW-1:0] LastVtx = VtxW'(5);

  typedef enum logic [FaceW-1:0] {
    FACE_FRONT  = 3'd0,
    FACE_BACK   = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_TOP    = 3'd4,
    FACE_BOTTOM = 3'd5
  } face_e;

  typedef struct packed {
    logic signed [NormW-1:0] x;
    logic signed [NormW-1:0] y;
    logic signed [NormW-1:0] z;
  } norm_t;

  function automatic norm_t face_normal(input logic [FaceW-1:0] f);
    norm_t n;
    n = '0;
    unique case (f)
      FACE_FRONT:  n.z = NormW'(1);
      FACE_BACK:   n.z = -NormW'(1);
      FACE_LEFT:   n.x = -NormW'(1);
      FACE_RIGHT:  n.x = NormW'(1);
      FACE_TOP:    n.y = NormW'(1);
      FACE_BOTTOM: n.y = -NormW'(1);
      default:     n = '0;
    endcase
    return n;
  endfunction

endpackage

[hdl/cube_face_tessellator_top.sv]
// Cube face tessellator. Each accepted tile (face, column, row) yields six vertices on
// consecutive cycles, one per cycle, top-left, bottom-left, bottom-right, bottom-right,
// top-right, top-left; a tile outside the grid, or a face code above five, yields a
// single result with bad_tile_o and last_vertex_o set and all other fields zero. busy_o
// drops on the cycle the final vertex of an item is issued, so items stream back to back.
// Each vertex passes the issue stage, then the corner-index, reciprocal-multiply and
// placement stages. Results are strobed by vertex_valid_o for one cycle and cannot be
// stalled. Write divisions only while idle; values above 64 saturate to 64, zero makes
// every tile bad.
module cube_face_tessellator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cft_pkg::DivW-1:0]        cfg_wdata_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [cft_pkg::FaceW-1:0]       face_i,
  input  logic [cft_pkg::IdxW-1:0]        column_i,
  input  logic [cft_pkg::IdxW-1:0]        row_i,
  output logic                            vertex_valid_o,
  output logic signed [cft_pkg::PosW-1:0] pos_x_o,
  output logic signed [cft_pkg::PosW-1:0] pos_y_o,
  output logic signed [cft_pkg::PosW-1:0] pos_z_o,
  output logic signed [cft_pkg::NormW-1:0] norm_x_o,
  output logic signed [cft_pkg::NormW-1:0] norm_y_o,
  output logic signed [cft_pkg::NormW-1:0] norm_z_o,
  output logic [cft_pkg::PosW-1:0]        tex_u_o,
  output logic [cft_pkg::PosW-1:0]        tex_v_o,
  output logic                            last_vertex_o,
  output logic                            bad_tile_o
);

  localparam int unsigned DivW  = cft_pkg::DivW;
  localparam int unsigned PosW  = cft_pkg::PosW;
  localparam int unsigned SumW  = PosW + 1;

  // reciprocal table
  logic [cft_pkg::RcpW-1:0] rcp_tab [cft_pkg::MaxDivisions+1];

  assign rcp_tab[0] = '0;
  for (genvar g = 1; g <= cft_pkg::MaxDivisions; g++) begin : g_rcp
    localparam longint unsigned RcpVal =
      ((64'd1 << cft_pkg::RcpShift) + 64'(2 * g) - 64'd1) / 64'(2 * g);
    assign rcp_tab[g] = cft_pkg::RcpW'(RcpVal);
  end

  // configuration
  logic [DivW-1:0]          n_q;
  logic [cft_pkg::RcpW-1:0] rcp_q;
  logic [DivW-1:0]          n_sat;

  assign n_sat = (cfg_wdata_i > DivW'(cft_pkg::MaxDivisions)) ?
                 DivW'(cft_pkg::MaxDivisions) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= DivW'(1);
      rcp_q <= cft_pkg::RcpW'(cft_pkg::RcpOne);
    end else if (cfg_we_i) begin
      n_q   <= n_sat;
      rcp_q <= rcp_tab[n_sat];
    end
  end

  // issue stage: hold the item and step through its vertices
  logic                         act_q;
  logic                         err_q;
  logic [cft_pkg::VtxW-1:0]     vi_q;
  logic [cft_pkg::FaceW-1:0]    face_q;
  logic [cft_pkg::IdxW-1:0]     col_q;
  logic [cft_pkg::IdxW-1:0]     row_q;
  logic                         issue_last;
  logic                         accept;
  logic                         in_err;

  assign issue_last = err_q || (vi_q == cft_pkg::LastVtx);
  assign busy_o     = act_q && !issue_last;
  assign accept     = start_i && !busy_o;
  assign in_err     = (face_i > cft_pkg::FACE_BOTTOM) ||
                      ({1'b0, column_i} >= n_q) || ({1'b0, row_i} >= n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      err_q <= 1'b0;
      vi_q  <= '0;
    end else if (accept) begin
      act_q <= 1'b1;
      err_q <= in_err;
      vi_q  <= '0;
    end else if (act_q) begin
      act_q <= !issue_last;
      vi_q  <= vi_q + cft_pkg::VtxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      face_q <= face_i;
      col_q  <= column_i;
      row_q  <= row_i;
    end
  end

  logic            inc_c;
  logic            inc_r;
  logic [DivW-1:0] ci_d;
  logic [DivW-1:0] rj_d;

  assign inc_c = (vi_q == cft_pkg::VtxW'(2)) || (vi_q == cft_pkg::VtxW'(3)) ||
                 (vi_q == cft_pkg::VtxW'(4));
  assign inc_r = (vi_q == cft_pkg::VtxW'(1)) || (vi_q == cft_pkg::VtxW'(2)) ||
                 (vi_q == cft_pkg::VtxW'(3));
  assign ci_d  = {1'b0, col_q} + DivW'(inc_c);
  assign rj_d  = {1'b0, row_q} + DivW'(inc_r);

  // stage 1: corner indexes
  logic                      s1_vld_q;
  logic                      s1_err_q;
  logic                      s1_last_q;
  logic [cft_pkg::FaceW-1:0] s1_face_q;
  logic [DivW-1:0]           s1_ci_q;
  logic [DivW-1:0]           s1_rj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_err_q  <= err_q;
    s1_last_q <= issue_last;
    s1_face_q <= face_q;
    s1_ci_q   <= ci_d;
    s1_rj_q   <= rj_d;
  end

  // stage 2: round(k * 2^FracBits / n) by reciprocal multiply
  logic [cft_pkg::NumW-1:0]  num_a;
  logic [cft_pkg::NumW-1:0]  num_b;
  logic [cft_pkg::ProdW-1:0] prod_a;
  logic [cft_pkg::ProdW-1:0] prod_b;

  assign num_a  = (cft_pkg::NumW'(s1_ci_q) << (cft_pkg::FracBits + 1)) +
                  cft_pkg::NumW'(n_q);
  assign num_b  = (cft_pkg::NumW'(s1_rj_q) << (cft_pkg::FracBits + 1)) +
                  cft_pkg::NumW'(n_q);
  assign prod_a = cft_pkg::ProdW'(num_a) * cft_pkg::ProdW'(rcp_q);
  assign prod_b = cft_pkg::ProdW'(num_b) * cft_pkg::ProdW'(rcp_q);

  logic                      s2_vld_q;
  logic                      s2_err_q;
  logic                      s2_last_q;
  logic [cft_pkg::FaceW-1:0] s2_face_q;
  logic [PosW-1:0]           s2_sa_q;
  logic [PosW-1:0]           s2_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_err_q  <= s1_err_q;
    s2_last_q <= s1_last_q;
    s2_face_q <= s1_face_q;
    s2_sa_q   <= prod_a[cft_pkg::RcpShift +: PosW];
    s2_sb_q   <= prod_b[cft_pkg::RcpShift +: PosW];
  end

  // stage 3: place the corner on its face
  logic signed [SumW-1:0] hp;
  logic signed [SumW-1:0] sa_s;
  logic signed [SumW-1:0] sb_s;
  logic signed [SumW-1:0] px_d;
  logic signed [SumW-1:0] py_d;
  logic signed [SumW-1:0] pz_d;
  logic [SumW-1:0]        tv_d;
  cft_pkg::norm_t         nrm_d;

  assign hp   = SumW'(cft_pkg::Half);
  assign sa_s = $signed({1'b0, s2_sa_q});
  assign sb_s = $signed({1'b0, s2_sb_q});
  assign tv_d = SumW'(cft_pkg::One) - {1'b0, s2_sb_q};

  always_comb begin
    px_d  = '0;
    py_d  = '0;
    pz_d  = '0;
    nrm_d = cft_pkg::face_normal(s2_face_q);
    unique case (s2_face_q)
      cft_pkg::FACE_FRONT: begin
        px_d = sa_s - hp;
        py_d = hp - sb_s;
        pz_d = hp;
      end
      cft_pkg::FACE_BACK: begin
        px_d = hp - sa_s;
        py_d = hp - sb_s;
        pz_d = -hp;
      end
      cft_pkg::FACE_LEFT: begin
        px_d = -hp;
        py_d = hp - sb_s;
        pz_d = sa_s - hp;
      end
      cft_pkg::FACE_RIGHT: begin
        px_d = hp;
        py_d = hp - sb_s;
        pz_d = hp - sa_s;
      end
      cft_pkg::FACE_TOP: begin
        px_d = sa_s - hp;
        py_d = hp;
        pz_d = sb_s - hp;
      end
      cft_pkg::FACE_BOTTOM: begin
        px_d = sa_s - hp;
        py_d = -hp;
        pz_d = hp - sb_s;
      end
      default: begin
        px_d = '0;
        py_d = '0;
        pz_d = '0;
      end
    endcase
  end

  logic s3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    last_vertex_o <= s2_last_q;
    bad_tile_o    <= s2_err_q;
    if (s2_err_q) begin
      pos_x_o  <= '0;
      pos_y_o  <= '0;
      pos_z_o  <= '0;
      norm_x_o <= '0;
      norm_y_o <= '0;
      norm_z_o <= '0;
      tex_u_o  <= '0;
      tex_v_o  <= '0;
    end else begin
      pos_x_o  <= px_d[PosW-1:0];
      pos_y_o  <= py_d[PosW-1:0];
      pos_z_o  <= pz_d[PosW-1:0];
      norm_x_o <= nrm_d.x;
      norm_y_o <= nrm_d.y;
      norm_z_o <= nrm_d.z;
      tex_u_o  <= s2_sa_q;
      tex_v_o  <= tv_d[PosW-1:0];
    end
  end

  assign vertex_valid_o = s3_vld_q;

`include "cube_face_tessellator_top_assert.svh"

  `CFT_ASSERT_NOW(a_bad_is_last, vertex_valid_o && bad_tile_o, last_vertex_o)
  `CFT_ASSERT_SEQ(a_accept_to_result, start_i && !busy_o, ##4 vertex_valid_o)
  `CFT_ASSERT_NOW(a_six_in_a_row, vertex_valid_o && last_vertex_o && !bad_tile_o,
                  $past(vertex_valid_o, 5) && !$past(last_vertex_o, 1))

endmodule
